>>> sv/cfr_pkg.sv
// Shared types, codes and helper functions for the clock frame replacement block.
// Used by cfr_ctrl, cfr_dp and clock_frame_replacement; depends on nothing else.
package cfr_pkg;

   // Table geometry
   localparam int FRAMES  = 64;
   localparam int FRAME_W = $clog2(FRAMES);
   localparam int SCAN_W  = $clog2(2 * FRAMES);
   localparam int COUNT_W = $clog2(FRAMES + 1);

   // Stream widths
   localparam int REQ_W      = 13;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_W      = 10;
   localparam int RSP_DATA_W = 16;

   // Operation codes
   localparam logic [2:0] OP_TRACK     = 3'd0;
   localparam logic [2:0] OP_RELEASE   = 3'd1;
   localparam logic [2:0] OP_EVICT     = 3'd2;
   localparam logic [2:0] OP_REFERENCE = 3'd3;
   localparam logic [2:0] OP_SET_PIN   = 3'd4;

   // Page kinds
   localparam logic [1:0] KIND_FILE = 2'd0;
   localparam logic [1:0] KIND_BIN  = 2'd1;
   localparam logic [1:0] KIND_ANON = 2'd2;

   // Victim actions
   localparam logic [1:0] ACT_DISCARD   = 2'd0;
   localparam logic [1:0] ACT_WRITEBACK = 2'd1;
   localparam logic [1:0] ACT_SWAP      = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_NONE  = 2'd2;

   typedef logic [FRAME_W-1:0] frame_addr_type;
   typedef logic [5:0]         frame_field_type;

   // Request fields, operation in the lowest bits
   typedef struct packed {
      logic            is_write;
      logic            pin_value;
      logic [1:0]      page_kind;
      frame_field_type frame;
      logic [2:0]      operation;
   } request_type;

   // Result fields, status in the lowest bits
   typedef struct packed {
      logic [1:0]      victim_action;
      frame_field_type victim_frame;
      logic [1:0]      status;
   } result_type;

   // Per-frame record held in the frame memory
   typedef struct packed {
      logic       pinned;
      logic       accessed;
      logic       dirty;
      logic [1:0] kind;
   } record_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WRITE,
      ST_EV_START,
      ST_EV_SCAN,
      ST_RESP
   } ctrl_state_type;

   typedef enum logic [1:0] {
      RD_REQ,
      RD_HAND,
      RD_PTR
   } rd_sel_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       load_req;
      rd_sel_type rd_sel;
      logic       apply_op;
      logic       ev_start;
      logic       ev_scan;
      logic       load_rsp;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_evict;
      logic table_empty;
      logic victim_found;
      logic scan_last;
      logic rsp_free;
   } dp_status_type;

   // Step to the next frame, wrapping at the end of the table
   function automatic frame_addr_type next_addr(input frame_addr_type a);
      frame_addr_type r;
      if (a == frame_addr_type'(FRAMES - 1)) begin
         r = '0;
      end else begin
         r = a + frame_addr_type'(1);
      end
      return r;
   endfunction

   // Unknown kinds are stored as anonymous
   function automatic logic [1:0] clamp_kind(input logic [1:0] k);
      logic [1:0] r;
      if (k > KIND_ANON) begin
         r = KIND_ANON;
      end else begin
         r = k;
      end
      return r;
   endfunction

   // Choose what happens to the page held by a victim frame
   function automatic logic [1:0] pick_action(input record_type rec);
      logic [1:0] r;
      if (rec.kind == KIND_ANON) begin
         r = ACT_SWAP;
      end else if (rec.dirty) begin
         r = (rec.kind == KIND_FILE) ? ACT_WRITEBACK : ACT_SWAP;
      end else begin
         r = ACT_DISCARD;
      end
      return r;
   endfunction

endpackage

>>> sv/cfr_ctrl.sv
// Controller state machine for the clock frame replacement block.
// Depends on cfr_pkg; drives cfr_dp through cmd_type and reads dp_status_type.
module cfr_ctrl
   import cfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type sts,
   output cmd_type       cmd
);

   ctrl_state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence each request: fetch the frame record, then update or sweep
   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd.load_req = 1'b0;
      cmd.rd_sel   = RD_REQ;
      cmd.apply_op = 1'b0;
      cmd.ev_start = 1'b0;
      cmd.ev_scan  = 1'b0;
      cmd.load_rsp = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_sel = RD_REQ;
            state_in   = sts.is_evict ? ST_EV_START : ST_WRITE;
         end
         ST_WRITE: begin
            cmd.apply_op = 1'b1;
            state_in     = ST_RESP;
         end
         ST_EV_START: begin
            cmd.ev_start = 1'b1;
            cmd.rd_sel   = RD_HAND;
            state_in     = sts.table_empty ? ST_RESP : ST_EV_SCAN;
         end
         ST_EV_SCAN: begin
            cmd.ev_scan = 1'b1;
            cmd.rd_sel  = RD_PTR;
            if (sts.victim_found || sts.scan_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> sv/cfr_dp.sv
// Datapath for the clock frame replacement block: frame memory, resident bits,
// clock hand, sweep counters and the result register. Depends on cfr_pkg.
module cfr_dp
   import cfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output dp_status_type         sts,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   record_type     frame_mem [FRAMES];
   logic [FRAMES-1:0] resident_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   frame_addr_type hand_ff, hand_in;
   frame_addr_type ptr_ff;
   frame_addr_type addr_q_ff;
   logic [SCAN_W-1:0] cnt_ff;
   logic           res_q_ff;
   record_type     rdata_ff;
   request_type    req_ff;
   result_type     res_ff, res_in;
   result_type     rsp_ff;
   logic           rsp_valid_ff;

   frame_addr_type rd_addr;
   record_type     rec;
   record_type     wr_data;
   logic           wr_en;
   logic           res_set;
   logic           res_clr;
   logic           eligible;
   logic           victim;
   logic           req_ok;

   // Select the frame to read this cycle
   always_comb begin
      case (cmd.rd_sel)
         RD_REQ:  rd_addr = frame_addr_type'(req_ff.frame);
         RD_HAND: rd_addr = hand_ff;
         RD_PTR:  rd_addr = ptr_ff;
         default: rd_addr = frame_addr_type'(req_ff.frame);
      endcase
   end

   // A frame that is not resident reads as an empty record
   assign rec      = res_q_ff ? rdata_ff : '0;
   assign eligible = res_q_ff & ~rdata_ff.pinned;
   assign victim   = eligible & ~rdata_ff.accessed;
   assign req_ok   = int'(req_ff.frame) < FRAMES;

   // Status towards the controller
   assign sts.is_evict     = (req_ff.operation == OP_EVICT);
   assign sts.table_empty  = (count_ff == '0);
   assign sts.victim_found = victim;
   assign sts.scan_last    = (cnt_ff == SCAN_W'(2 * FRAMES - 1));
   assign sts.rsp_free     = ~rsp_valid_ff | rsp_tready;

   // Work out record, residency, hand and result updates
   always_comb begin
      wr_en    = 1'b0;
      wr_data  = rec;
      res_set  = 1'b0;
      res_clr  = 1'b0;
      count_in = count_ff;
      hand_in  = hand_ff;
      res_in   = res_ff;
      if (cmd.apply_op) begin
         res_in        = '0;
         res_in.status = ST_OK;
         if (req_ok) begin
            case (req_ff.operation)
               OP_TRACK: begin
                  wr_en            = 1'b1;
                  wr_data.pinned   = req_ff.pin_value;
                  wr_data.accessed = 1'b0;
                  wr_data.dirty    = 1'b0;
                  wr_data.kind     = clamp_kind(req_ff.page_kind);
                  res_set          = 1'b1;
                  if (!res_q_ff) begin
                     count_in = count_ff + COUNT_W'(1);
                  end
               end
               OP_RELEASE: begin
                  if (res_q_ff) begin
                     res_clr  = 1'b1;
                     count_in = count_ff - COUNT_W'(1);
                  end
               end
               OP_REFERENCE: begin
                  if (res_q_ff) begin
                     wr_en            = 1'b1;
                     wr_data.accessed = 1'b1;
                     wr_data.dirty    = rec.dirty | req_ff.is_write;
                  end
               end
               OP_SET_PIN: begin
                  if (res_q_ff) begin
                     wr_en          = 1'b1;
                     wr_data.pinned = req_ff.pin_value;
                  end
               end
               default: begin
               end
            endcase
         end
      end else if (cmd.ev_start) begin
         res_in = '0;
         res_in.status = sts.table_empty ? ST_EMPTY : ST_OK;
      end else if (cmd.ev_scan) begin
         // Second chance: drop the accessed bit and move on
         if (eligible && rdata_ff.accessed) begin
            wr_en            = 1'b1;
            wr_data.accessed = 1'b0;
         end
         if (victim) begin
            res_clr              = 1'b1;
            count_in             = count_ff - COUNT_W'(1);
            hand_in              = next_addr(addr_q_ff);
            res_in.status        = ST_OK;
            res_in.victim_frame  = frame_field_type'(addr_q_ff);
            res_in.victim_action = pick_action(rdata_ff);
         end else if (sts.scan_last) begin
            res_in.status = ST_NONE;
         end
      end
   end

   // Frame memory: registered read, single write port
   always_ff @(posedge clock) begin
      rdata_ff <= frame_mem[rd_addr];
      if (wr_en) begin
         frame_mem[addr_q_ff] <= wr_data;
      end
   end

   // Control state: resident bits, fill count, clock hand, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         resident_ff  <= '0;
         count_ff     <= '0;
         hand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (res_set) begin
            resident_ff[addr_q_ff] <= 1'b1;
         end
         if (res_clr) begin
            resident_ff[addr_q_ff] <= 1'b0;
         end
         count_ff <= count_in;
         hand_ff  <= hand_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: request, read pipeline, sweep pointer, results
   always_ff @(posedge clock) begin
      res_q_ff  <= resident_ff[rd_addr];
      addr_q_ff <= rd_addr;
      res_ff    <= res_in;
      if (cmd.load_req) begin
         req_ff <= request_type'(req_tdata[REQ_W-1:0]);
      end
      if (cmd.ev_start) begin
         ptr_ff <= next_addr(hand_ff);
         cnt_ff <= '0;
      end else if (cmd.ev_scan) begin
         ptr_ff <= next_addr(ptr_ff);
         cnt_ff <= cnt_ff + SCAN_W'(1);
      end
      if (cmd.load_rsp) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_W){1'b0}}, rsp_ff};

endmodule

>>> sv/clock_frame_replacement.sv
// Frame table with second-chance clock replacement. Track, release, reference and
// set pin read the frame record and then apply the update; evict reports an empty
// table, or else sweeps the frame memory one frame per cycle from the clock hand
// (at most two passes) until it finds a victim.
// One request is in work at a time; the next is taken while the last result waits.
// Synchronous reset empties the table.
module clock_frame_replacement
   import cfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // operation[2:0], frame[8:3], page_kind[10:9], pin_value[11], is_write[12]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status[1:0], victim_frame[7:2], victim_action[9:8]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   cmd_type       cmd;
   dp_status_type sts;

   cfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cfr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Every request keeps the block busy for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous one still in work");

   // Only defined status codes leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == ST_OK || rsp_tdata[1:0] == ST_EMPTY
                      || rsp_tdata[1:0] == ST_NONE))
      else $error("undefined status in result");

   // A failed evict reports no victim
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != ST_OK) |-> (rsp_tdata[9:2] == '0))
      else $error("victim reported with error status");

   // A sweep never starts on an empty table
   assert property (@(posedge clock) disable iff (reset)
      cmd.ev_scan |-> $past(cmd.ev_scan) || !$past(sts.table_empty))
      else $error("sweep entered with empty table");

endmodule

>>> bench/tb_clock_frame_replacement.sv
// Self-checking bench for clock_frame_replacement: drives frame-table requests over the
// request stream, predicts each result with its own second-chance table and checks it.
// Depends on cfr_pkg and clock_frame_replacement only.
module tb_clock_frame_replacement;
   import cfr_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 3;
   localparam int STALL_LIMIT  = 4000;
   localparam int SETTLE_WAIT  = 2 * FRAMES + 16;
   localparam int RANDOM_ITEMS = 1300;
   localparam int MAX_REPORTS  = 10;
   localparam int PHASES       = 3;

   // Operation codes the block does not define
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   // Pending request with the idling phase it belongs to
   typedef struct {
      request_type req;
      int          phase;
      bit          drain;
   } req_item_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Idle chance in percent per phase, sender and receiver
   int send_idle_pct [PHASES] = '{9, 56, 0};
   int recv_idle_pct [PHASES] = '{56, 9, 0};

   req_item_type pending_reqs [$];
   result_type   expected_results [$];
   req_item_type next_item;
   int           fill_phase = 0;
   int           drive_phase = 0;
   int           mismatches = 0;
   int           quiet_cycles = 0;

   // Predicted frame table
   bit         tbl_resident [FRAMES];
   bit         tbl_pinned   [FRAMES];
   bit         tbl_accessed [FRAMES];
   bit         tbl_dirty    [FRAMES];
   logic [1:0] tbl_kind     [FRAMES];
   int         tbl_hand = 0;

   clock_frame_replacement u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Apply one request to the predicted table and return the result it gives
   function automatic result_type predict_outcome(input request_type rq);
      result_type res;
      int         f;
      int         idx;
      int         i;
      bit         found;
      bit         occupied;
      res = '0;
      res.status = ST_OK;
      res.victim_action = ACT_DISCARD;
      f = int'(rq.frame);
      if (rq.operation == OP_EVICT) begin
         occupied = 1'b0;
         for (i = 0; i < FRAMES; i++) begin
            if (tbl_resident[i]) occupied = 1'b1;
         end
         if (!occupied) begin
            res.status = ST_EMPTY;
         end else begin
            // Sweep up to two passes; the first may only clear accessed bits
            res.status = ST_NONE;
            found = 1'b0;
            for (i = 0; i < 2 * FRAMES && !found; i++) begin
               idx = (tbl_hand + i) % FRAMES;
               if (tbl_resident[idx] && !tbl_pinned[idx]) begin
                  if (tbl_accessed[idx]) begin
                     tbl_accessed[idx] = 1'b0;
                  end else begin
                     found = 1'b1;
                     res.status = ST_OK;
                     res.victim_frame = idx[5:0];
                     if (tbl_kind[idx] == KIND_ANON) begin
                        res.victim_action = ACT_SWAP;
                     end else if (tbl_dirty[idx]) begin
                        res.victim_action = (tbl_kind[idx] == KIND_FILE) ? ACT_WRITEBACK
                                                                          : ACT_SWAP;
                     end
                     tbl_resident[idx] = 1'b0;
                     tbl_pinned[idx]   = 1'b0;
                     tbl_accessed[idx] = 1'b0;
                     tbl_dirty[idx]    = 1'b0;
                     tbl_kind[idx]     = KIND_FILE;
                     tbl_hand = (idx + 1) % FRAMES;
                  end
               end
            end
         end
      end else if (f < FRAMES) begin
         case (rq.operation)
            OP_TRACK: begin
               tbl_resident[f] = 1'b1;
               tbl_pinned[f]   = rq.pin_value;
               tbl_accessed[f] = 1'b0;
               tbl_dirty[f]    = 1'b0;
               tbl_kind[f]     = (rq.page_kind > KIND_ANON) ? KIND_ANON : rq.page_kind;
            end
            OP_RELEASE: begin
               tbl_resident[f] = 1'b0;
               tbl_pinned[f]   = 1'b0;
               tbl_accessed[f] = 1'b0;
               tbl_dirty[f]    = 1'b0;
               tbl_kind[f]     = KIND_FILE;
            end
            OP_REFERENCE: begin
               if (tbl_resident[f]) begin
                  tbl_accessed[f] = 1'b1;
                  if (rq.is_write) tbl_dirty[f] = 1'b1;
               end
            end
            OP_SET_PIN: begin
               if (tbl_resident[f]) tbl_pinned[f] = rq.pin_value;
            end
            default: begin
            end
         endcase
      end
      return res;
   endfunction

   // Append one request to the pending queue in the current phase
   task automatic queue_request(input logic [2:0] op, input int frame, input int kind,
                                input bit pin, input bit wr, input bit drain);
      req_item_type it;
      it.req.operation = op;
      it.req.frame     = frame[5:0];
      it.req.page_kind = kind[1:0];
      it.req.pin_value = pin;
      it.req.is_write  = wr;
      it.phase         = fill_phase;
      it.drain         = drain;
      pending_reqs.push_back(it);
   endtask

   // Request driver: predict on acceptance, present the next pending request when free
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(predict_outcome(request_type'(req_tdata[REQ_W-1:0])));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 &&
                (!pending_reqs[0].drain || expected_results.size() == 0) &&
                $urandom_range(99) >= send_idle_pct[pending_reqs[0].phase]) begin
               next_item = pending_reqs.pop_front();
               req_tvalid  <= 1'b1;
               req_tdata   <= {{(REQ_DATA_W - REQ_W){1'b0}}, next_item.req};
               drive_phase <= next_item.phase;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: stall at random, compare each result with the oldest prediction
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct[drive_phase]);
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[RSP_W-1:0]);
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result: status %0d frame %0d action %0d",
                           got.status, got.victim_frame, got.victim_action);
            end else begin
               want = expected_results.pop_front();
               if (got.status != want.status || got.victim_frame != want.victim_frame ||
                   got.victim_action != want.victim_action) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("result mismatch: status %0d/%0d frame %0d/%0d action %0d/%0d",
                              want.status, got.status, want.victim_frame, got.victim_frame,
                              want.victim_action, got.victim_action);
               end
            end
         end
      end
   end

   // Watchdog: give up when nothing moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("** clock_frame_replacement: FAILED **");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int n;
      int sel;
      int frame;
      int count;
      logic [2:0] op;
      for (n = 0; n < FRAMES; n++) begin
         tbl_resident[n] = 1'b0;
         tbl_pinned[n]   = 1'b0;
         tbl_accessed[n] = 1'b0;
         tbl_dirty[n]    = 1'b0;
         tbl_kind[n]     = KIND_FILE;
      end

      // Directed: empty table, clamped kind, pinning, all pinned, each victim action
      fill_phase = 0;
      queue_request(OP_EVICT,     0,  0, 0, 0, 0);
      queue_request(OP_TRACK,     0,  KIND_FILE, 0, 0, 0);
      queue_request(OP_TRACK,     63, KIND_ANON, 1, 1, 0);
      queue_request(OP_TRACK,     5,  3, 0, 1, 0);
      queue_request(OP_REFERENCE, 0,  0, 1, 1, 0);
      queue_request(OP_REFERENCE, 10, 3, 1, 1, 0);
      queue_request(OP_SET_PIN,   11, 0, 1, 0, 0);
      queue_request(OP_RELEASE,   12, 0, 0, 0, 0);
      queue_request(OP_SET_PIN,   5,  0, 1, 0, 0);
      queue_request(OP_EVICT,     0,  0, 0, 0, 0);
      queue_request(OP_EVICT,     63, 3, 1, 1, 0);
      queue_request(OP_SET_PIN,   5,  0, 0, 0, 0);
      queue_request(OP_RELEASE,   63, 0, 0, 0, 0);
      queue_request(OP_TRACK,     63, KIND_BIN, 0, 0, 0);
      queue_request(OP_REFERENCE, 63, 0, 0, 1, 0);
      queue_request(OP_EVICT,     0,  0, 0, 0, 0);
      queue_request(OP_EVICT,     0,  0, 0, 0, 0);
      queue_request(OP_TRACK,     7,  KIND_BIN, 0, 0, 0);
      queue_request(OP_TRACK,     8,  KIND_FILE, 0, 0, 0);
      queue_request(OP_REFERENCE, 8,  0, 0, 1, 0);
      queue_request(OP_TRACK,     8,  KIND_FILE, 0, 1, 0);
      queue_request(OP_RELEASE,   0,  0, 0, 0, 0);
      queue_request(OP_SPARE_FIRST, 63, 3, 1, 1, 0);
      queue_request(OP_SPARE_LAST,  7,  2, 1, 1, 0);
      queue_request(OP_EVICT,     0,  0, 0, 0, 0);
      queue_request(OP_EVICT,     0,  0, 0, 0, 0);

      // Random mix over three idling phases; now and then pause until all results are in
      for (fill_phase = 0; fill_phase < PHASES; fill_phase++) begin
         count = 0;
         while (count < RANDOM_ITEMS / PHASES) begin
            sel = $urandom_range(99);
            if (sel < 30)      op = OP_TRACK;
            else if (sel < 55) op = OP_REFERENCE;
            else if (sel < 75) op = OP_EVICT;
            else if (sel < 85) op = OP_RELEASE;
            else if (sel < 95) op = OP_SET_PIN;
            else               op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
            // Favour a few frames so that requests collide
            frame = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(FRAMES - 1);
            queue_request(op, frame, $urandom_range(3),
                          (op == OP_TRACK) ? ($urandom_range(99) < 15)
                                           : 1'($urandom_range(1)),
                          1'($urandom_range(1)), (count == 0) || (count % 150 == 75));
            count++;
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last request and its result, then let the block settle
      while (pending_reqs.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("** clock_frame_replacement: PASSED **");
      end else begin
         $display("** clock_frame_replacement: FAILED **");
      end
      $finish;
   end

endmodule

>>> clock_frame_replacement.f
sv/cfr_pkg.sv
sv/cfr_ctrl.sv
sv/cfr_dp.sv
sv/clock_frame_replacement.sv
bench/tb_clock_frame_replacement.sv
